// ===== rtl/core/rbd_pkg.sv =====
// Package for the retry backoff delay unit: strategy codes, register indexes,
// sequencer states and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned FACTOR_FRAC_BITS = 8;

  localparam int unsigned DELAY_W  = 64;
  localparam int unsigned ATTEMPT_W = 32;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned STRAT_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned HALF_W  = DELAY_W / 2;
  localparam int unsigned PROD_W  = HALF_W + FACTOR_W;
  localparam int unsigned FULL_W  = DELAY_W + FACTOR_W;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned DIVR_W  = LIMIT_W + 1;

  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DELAY_W);

  localparam logic [STRAT_W-1:0]  STRATEGY_RST   = 3'd3;
  localparam logic [DELAY_W-1:0]  INIT_DELAY_RST = 64'd100000000;
  localparam logic [DELAY_W-1:0]  MAX_DELAY_RST  = 64'd30000000000;
  localparam logic [FACTOR_W-1:0] GROWTH_RST     =
    FACTOR_W'((32'd2 << FACTOR_FRAC_BITS) & 32'h0000_FFFF);
  localparam logic [LIMIT_W-1:0]  RETRY_LIMIT_RST = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRATEGY      = 3'd0,
    REG_INITIAL_DELAY = 3'd1,
    REG_MAX_DELAY     = 3'd2,
    REG_GROWTH_FACTOR = 3'd3,
    REG_RETRY_LIMIT   = 3'd4
  } reg_idx_e;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_NONE     = 3'd0,
    STRAT_CONSTANT = 3'd1,
    STRAT_LINEAR   = 3'd2,
    STRAT_EXPONENT = 3'd3,
    STRAT_JITTERED = 3'd4
  } strategy_e;

  typedef enum logic [1:0] {
    MODE_LIN,
    MODE_EXP,
    MODE_JIT
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_DIV,
    ST_DSUB,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/core/retry_backoff_delay_unit.sv =====
// Retry backoff delay unit: one shared 32x16 multiplier and a bit-serial divider
// under a small sequencer. Depends on rbd_pkg.
//
// Channel   Signals                                   Direction
// in        in_valid_i, in_ready_o, attempt_number_i  transfer in
// out       out_valid_o, out_ready_i, delay_ns_o      transfer out
// cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i          write only
//
// Sequence per item: limit hit, none, constant and unknown strategies go straight to
// the finish state; linear takes one growth step; exponential takes one per attempt
// (each growth step is two multiplier passes and one add, cap and compare; the loop
// stops early once the cap is hit); jittered adds the 64-step divider.
// Reset clears the sequencer, the output valid and the config registers to defaults.
// A new item is taken while a finished result still waits on the output register.
`timescale 1ns / 1ps

module retry_backoff_delay_unit import rbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DELAY_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ATTEMPT_W-1:0] attempt_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DELAY_W-1:0]   delay_ns_o
);

  logic [STRAT_W-1:0]  strategy_q;
  logic [DELAY_W-1:0]  init_delay_q;
  logic [DELAY_W-1:0]  max_delay_q;
  logic [FACTOR_W-1:0] growth_q;
  logic [LIMIT_W-1:0]  retry_limit_q;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic                out_valid_q, out_valid_d;
  logic [DELAY_W-1:0]  out_q, out_d;
  logic [DELAY_W-1:0]  d_q, d_d;
  logic [DELAY_W-1:0]  dv_q, dv_d;
  logic [LIMIT_W-1:0]  rem_q, rem_d;
  logic [LIMIT_W-1:0]  att_q, att_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PROD_W-1:0]   plo_q, plo_d;
  logic [PROD_W-1:0]   phi_q, phi_d;

  logic [HALF_W-1:0]   mul_a;
  logic [FACTOR_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [FULL_W-1:0]   full;
  logic [FULL_W-1:0]   scaled;
  logic [DELAY_W-1:0]  grown;
  logic [DIVR_W-1:0]   divisor;
  logic [DIVR_W-1:0]   rext;
  logic                rge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q    <= STRATEGY_RST;
      init_delay_q  <= INIT_DELAY_RST;
      max_delay_q   <= MAX_DELAY_RST;
      growth_q      <= GROWTH_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_STRATEGY:      strategy_q    <= cfg_wdata_i[STRAT_W-1:0];
        REG_INITIAL_DELAY: init_delay_q  <= cfg_wdata_i;
        REG_MAX_DELAY:     max_delay_q   <= cfg_wdata_i;
        REG_GROWTH_FACTOR: growth_q      <= cfg_wdata_i[FACTOR_W-1:0];
        REG_RETRY_LIMIT:   retry_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier and growth datapath
  assign mul_a = (state_q == ST_MUL_LO) ? d_q[HALF_W-1:0] : d_q[DELAY_W-1:HALF_W];
  assign mul_b = (mode_q == MODE_LIN) ? (FACTOR_W'(att_q) + FACTOR_W'(1)) : growth_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign full   = {phi_q, {HALF_W{1'b0}}} + FULL_W'(plo_q);
  assign scaled = (mode_q == MODE_LIN) ? full : (full >> FACTOR_FRAC_BITS);
  assign grown  = (|scaled[FULL_W-1:DELAY_W]) ? {DELAY_W{1'b1}} : scaled[DELAY_W-1:0];

  // bit-serial divide by attempt+2
  assign divisor = DIVR_W'(att_q) + DIVR_W'(2);
  assign rext    = {rem_q, dv_q[DELAY_W-1]};
  assign rge     = (rext >= divisor);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign delay_ns_o  = out_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    d_d         = d_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    att_d       = att_q;
    cnt_d       = cnt_q;
    plo_d       = plo_q;
    phi_d       = phi_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          att_d = attempt_number_i[LIMIT_W-1:0];
          d_d   = init_delay_q;
          cnt_d = CNT_W'(attempt_number_i[LIMIT_W-1:0]);
          if (attempt_number_i >= ATTEMPT_W'(retry_limit_q)) begin
            d_d     = max_delay_q;
            state_d = ST_FINISH;
          end else begin
            case (strategy_e'(strategy_q))
              STRAT_NONE: begin
                d_d     = '0;
                state_d = ST_FINISH;
              end
              STRAT_LINEAR: begin
                mode_d  = MODE_LIN;
                cnt_d   = CNT_W'(1);
                state_d = ST_MUL_LO;
              end
              STRAT_EXPONENT: begin
                mode_d  = MODE_EXP;
                state_d = (attempt_number_i[LIMIT_W-1:0] == '0) ? ST_FINISH : ST_MUL_LO;
              end
              STRAT_JITTERED: begin
                mode_d = MODE_JIT;
                if (attempt_number_i[LIMIT_W-1:0] == '0) begin
                  dv_d    = init_delay_q;
                  rem_d   = '0;
                  cnt_d   = DIV_STEPS;
                  state_d = ST_DIV;
                end else begin
                  state_d = ST_MUL_LO;
                end
              end
              default: begin
                state_d = ST_FINISH;
              end
            endcase
          end
        end
      end
      ST_MUL_LO: begin
        plo_d   = mul_p;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        phi_d   = mul_p;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (grown > max_delay_q || cnt_q == CNT_W'(1)) begin
          d_d = (grown > max_delay_q) ? max_delay_q : grown;
          if (mode_q == MODE_JIT) begin
            dv_d    = (grown > max_delay_q) ? max_delay_q : grown;
            rem_d   = '0;
            cnt_d   = DIV_STEPS;
            state_d = ST_DIV;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          d_d     = grown;
          state_d = ST_MUL_LO;
        end
      end
      ST_DIV: begin
        rem_d = rge ? LIMIT_W'(rext - divisor) : rext[LIMIT_W-1:0];
        dv_d  = {dv_q[DELAY_W-2:0], rge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DSUB;
        end
      end
      ST_DSUB: begin
        d_d     = d_q - dv_q;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = d_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_EXP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    d_q   <= d_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    att_q <= att_d;
    cnt_q <= cnt_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
  end

endmodule

// ===== rtl/core/rbd_checker.sv =====
// Port-level checks for the retry backoff delay unit, bound to the top level.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_port_assert import rbd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [DELAY_W-1:0] delay_ns_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(delay_ns_o))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an input transfer");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("new result without return to ready");

endmodule

bind retry_backoff_delay_unit rbd_port_assert u_rbd_port_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .delay_ns_o  (delay_ns_o)
);
